// File: rtl/bace_pkg.sv
package bace_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int ADDR_W    = 12;
    localparam int WORD_W    = 16;
    localparam int CHAR_W    = 8;

    // item kinds
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_LOAD    = 3'd1;
    localparam logic [2:0] FUNC_INPUT   = 3'd2;
    localparam logic [2:0] FUNC_OUT_TGL = 3'd3;
    localparam logic [2:0] FUNC_RESTART = 3'd4;

    // memory-reference opcodes (bits 14:12)
    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_LDA = 3'd2;
    localparam logic [2:0] OP_STA = 3'd3;
    localparam logic [2:0] OP_BUN = 3'd4;
    localparam logic [2:0] OP_BSA = 3'd5;
    localparam logic [2:0] OP_ISZ = 3'd6;
    localparam logic [2:0] OP_REG = 3'd7;

    // register-reference codes
    localparam logic [15:0] RR_CLA = 16'h7800;
    localparam logic [15:0] RR_CLE = 16'h7400;
    localparam logic [15:0] RR_CMA = 16'h7200;
    localparam logic [15:0] RR_CME = 16'h7100;
    localparam logic [15:0] RR_CIR = 16'h7080;
    localparam logic [15:0] RR_CIL = 16'h7040;
    localparam logic [15:0] RR_INC = 16'h7020;
    localparam logic [15:0] RR_SPA = 16'h7010;
    localparam logic [15:0] RR_SNA = 16'h7008;
    localparam logic [15:0] RR_SZA = 16'h7004;
    localparam logic [15:0] RR_SZE = 16'h7002;
    localparam logic [15:0] RR_HLT = 16'h7001;

    // I/O codes
    localparam logic [15:0] IO_INP = 16'hF800;
    localparam logic [15:0] IO_OUT = 16'hF400;
    localparam logic [15:0] IO_SKI = 16'hF200;
    localparam logic [15:0] IO_SKO = 16'hF100;
    localparam logic [15:0] IO_ION = 16'hF080;
    localparam logic [15:0] IO_IOF = 16'hF040;

    localparam logic [ADDR_W-1:0] START_RESET = 12'h100;

endpackage

// File: rtl/bace_ram.sv
module bace_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/basic_accumulator_cpu_execute.sv
// Accumulator machine execute block: 16-bit words, 4096-word memory.
// Request channel (in_valid/in_ready, fields func/addr/data) takes one item:
// tick, memory load, input character, output-flag toggle or restart.
// Every request gives one result on the out_valid/out_ready channel with
// the visible machine state after the item.
// Config channel (cfg_valid/cfg_ready, cfg_data) sets the restart PC; it
// is always ready and must be written only while the block is idle.
// Each request steps through states, with the single memory port and the
// shared adder: a tick fetches, decodes, reads a pointer for an indirect
// operand, then runs the operand, register or I/O step, with a PC step
// on a taken skip; an interrupt tick only saves the PC; a halted tick,
// load, input, toggle and restart go straight to the result.
// The result becomes valid as the block goes back to idle for the next one.
// After reset a clearing pass zeroes all 4096 memory words; no request
// is accepted meanwhile. A finished result sits in an output register, so
// a stalled receiver holds only the completion of the next request.
module basic_accumulator_cpu_execute (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [bace_pkg::ADDR_W-1:0]    addr,
    input  logic [bace_pkg::WORD_W-1:0]    data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bace_pkg::ADDR_W-1:0]    pc,
    output logic [bace_pkg::WORD_W-1:0]    acc,
    output logic                           carry_e,
    output logic                           int_enable,
    output logic                           in_flag,
    output logic                           out_flag,
    output logic                           int_pending,
    output logic [bace_pkg::CHAR_W-1:0]    out_char,
    output logic                           halted,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bace_pkg::ADDR_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_INDIR,
        S_OPER,
        S_EXEC,
        S_INTR,
        S_SKIP,
        S_DONE
    } state_t;

    localparam int AW = bace_pkg::ADDR_W;
    localparam int WW = bace_pkg::WORD_W;
    localparam int CW = bace_pkg::CHAR_W;

    state_t            state_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     start_reg;
    logic [AW-1:0]     pc_reg;
    logic [WW-1:0]     acc_reg;
    logic              e_reg;
    logic              ien_reg;
    logic              fgi_reg;
    logic              fgo_reg;
    logic              r_reg;
    logic              halt_reg;
    logic [CW-1:0]     inr_reg;
    logic [CW-1:0]     outr_reg;
    logic [WW-1:0]     ir_reg;
    logic [AW-1:0]     ea_reg;

    logic              out_valid_reg;
    logic [AW-1:0]     pc_out_reg;
    logic [WW-1:0]     acc_out_reg;
    logic              e_out_reg;
    logic              ien_out_reg;
    logic              fgi_out_reg;
    logic              fgo_out_reg;
    logic              r_out_reg;
    logic [CW-1:0]     outr_out_reg;
    logic              halt_out_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WW-1:0]     mem_wdata;
    logic [WW-1:0]     mem_rdata;

    logic [WW-1:0]     alu_a;
    logic [WW-1:0]     alu_b;
    logic [WW:0]       alu_sum;

    logic [2:0]        ir_op;
    logic              out_load;

    assign ir_op     = ir_reg[14:12];
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // main memory
    bace_ram #(
        .WIDTH (WW),
        .DEPTH (bace_pkg::MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // shared adder: PC increments, ADD, INC, ISZ, BSA target
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            S_FETCH, S_SKIP:
            begin
                alu_a = {{(WW-AW){1'b0}}, pc_reg};
                alu_b = WW'(1);
            end
            S_OPER:
            begin
                case (ir_op)
                    bace_pkg::OP_ADD:
                    begin
                        alu_a = acc_reg;
                        alu_b = mem_rdata;
                    end
                    bace_pkg::OP_ISZ:
                    begin
                        alu_a = mem_rdata;
                        alu_b = WW'(1);
                    end
                    bace_pkg::OP_BSA:
                    begin
                        alu_a = {{(WW-AW){1'b0}}, ea_reg};
                        alu_b = WW'(1);
                    end
                    default:
                    begin
                        alu_a = '0;
                        alu_b = '0;
                    end
                endcase
            end
            S_EXEC:
            begin
                alu_a = acc_reg;
                alu_b = WW'(1);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

    // memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            S_IDLE:
            begin
                mem_we    = in_valid && (func == bace_pkg::FUNC_LOAD);
                mem_addr  = addr;
                mem_wdata = data;
            end
            S_FETCH:
            begin
                mem_addr = pc_reg;
            end
            S_DECODE, S_INDIR:
            begin
                mem_addr = mem_rdata[AW-1:0];
            end
            S_OPER:
            begin
                mem_addr = ea_reg;
                case (ir_op)
                    bace_pkg::OP_STA:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = acc_reg;
                    end
                    bace_pkg::OP_BSA:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {{(WW-AW){1'b0}}, pc_reg};
                    end
                    bace_pkg::OP_ISZ:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = alu_sum[WW-1:0];
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            S_INTR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {{(WW-AW){1'b0}}, pc_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer, machine state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= bace_pkg::START_RESET;
            pc_reg        <= bace_pkg::START_RESET;
            acc_reg       <= '0;
            e_reg         <= 1'b0;
            ien_reg       <= 1'b0;
            fgi_reg       <= 1'b0;
            fgo_reg       <= 1'b0;
            r_reg         <= 1'b0;
            halt_reg      <= 1'b0;
            inr_reg       <= '0;
            outr_reg      <= '0;
            ir_reg        <= '0;
            ea_reg        <= '0;
            out_valid_reg <= 1'b0;
            pc_out_reg    <= '0;
            acc_out_reg   <= '0;
            e_out_reg     <= 1'b0;
            ien_out_reg   <= 1'b0;
            fgi_out_reg   <= 1'b0;
            fgo_out_reg   <= 1'b0;
            r_out_reg     <= 1'b0;
            outr_out_reg  <= '0;
            halt_out_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                start_reg <= cfg_data;
            end

            // result taken
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == {AW{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DONE;
                        case (func)
                            bace_pkg::FUNC_TICK:
                            begin
                                if (halt_reg)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else if (r_reg)
                                begin
                                    state_reg <= S_INTR;
                                end
                                else
                                begin
                                    if (ien_reg && (fgi_reg || fgo_reg))
                                    begin
                                        r_reg <= 1'b1;
                                    end
                                    state_reg <= S_FETCH;
                                end
                            end
                            bace_pkg::FUNC_INPUT:
                            begin
                                fgi_reg <= ~fgi_reg;
                                inr_reg <= data[CW-1:0];
                            end
                            bace_pkg::FUNC_OUT_TGL:
                            begin
                                fgo_reg <= ~fgo_reg;
                            end
                            bace_pkg::FUNC_RESTART:
                            begin
                                acc_reg  <= '0;
                                e_reg    <= 1'b0;
                                outr_reg <= '0;
                                inr_reg  <= '0;
                                ien_reg  <= 1'b0;
                                r_reg    <= 1'b0;
                                halt_reg <= 1'b0;
                                pc_reg   <= start_reg;
                            end
                            default:
                            begin
                                // load is written by the memory port; rest do nothing
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_FETCH:
                begin
                    pc_reg    <= alu_sum[AW-1:0];
                    state_reg <= S_DECODE;
                end

                // instruction word arrives; direct operand read goes out now
                S_DECODE:
                begin
                    ir_reg <= mem_rdata;
                    ea_reg <= mem_rdata[AW-1:0];
                    if (mem_rdata[14:12] == bace_pkg::OP_REG)
                    begin
                        state_reg <= S_EXEC;
                    end
                    else if (mem_rdata[WW-1])
                    begin
                        state_reg <= S_INDIR;
                    end
                    else
                    begin
                        state_reg <= S_OPER;
                    end
                end

                // pointer word arrives; low bits are the effective address
                S_INDIR:
                begin
                    ea_reg    <= mem_rdata[AW-1:0];
                    state_reg <= S_OPER;
                end

                S_OPER:
                begin
                    state_reg <= S_DONE;
                    case (ir_op)
                        bace_pkg::OP_AND:
                        begin
                            acc_reg <= acc_reg & mem_rdata;
                        end
                        bace_pkg::OP_ADD:
                        begin
                            acc_reg <= alu_sum[WW-1:0];
                            e_reg   <= alu_sum[WW];
                        end
                        bace_pkg::OP_LDA:
                        begin
                            acc_reg <= mem_rdata;
                        end
                        bace_pkg::OP_BUN:
                        begin
                            pc_reg <= ea_reg;
                        end
                        bace_pkg::OP_BSA:
                        begin
                            pc_reg <= alu_sum[AW-1:0];
                        end
                        bace_pkg::OP_ISZ:
                        begin
                            if (alu_sum[WW-1:0] == '0)
                            begin
                                state_reg <= S_SKIP;
                            end
                        end
                        default:
                        begin
                            // store is done by the memory port
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                // register and I/O codes
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    if (!ir_reg[WW-1])
                    begin
                        case (ir_reg)
                            bace_pkg::RR_CLA: acc_reg <= '0;
                            bace_pkg::RR_CLE: e_reg <= 1'b0;
                            bace_pkg::RR_CMA: acc_reg <= ~acc_reg;
                            bace_pkg::RR_CME: e_reg <= ~e_reg;
                            bace_pkg::RR_CIR:
                            begin
                                acc_reg <= {e_reg, acc_reg[WW-1:1]};
                                e_reg   <= acc_reg[0];
                            end
                            bace_pkg::RR_CIL:
                            begin
                                acc_reg <= {acc_reg[WW-2:0], e_reg};
                                e_reg   <= acc_reg[WW-1];
                            end
                            bace_pkg::RR_INC: acc_reg <= alu_sum[WW-1:0];
                            bace_pkg::RR_SPA:
                            begin
                                if (!acc_reg[WW-1])
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::RR_SNA:
                            begin
                                if (acc_reg[WW-1])
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::RR_SZA:
                            begin
                                if (acc_reg == '0)
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::RR_SZE:
                            begin
                                if (!e_reg)
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::RR_HLT: halt_reg <= 1'b1;
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        case (ir_reg)
                            bace_pkg::IO_INP:
                            begin
                                acc_reg <= {acc_reg[WW-1:CW], inr_reg};
                                fgi_reg <= 1'b0;
                            end
                            bace_pkg::IO_OUT:
                            begin
                                outr_reg <= acc_reg[CW-1:0];
                                fgo_reg  <= 1'b0;
                            end
                            bace_pkg::IO_SKI:
                            begin
                                if (fgi_reg)
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::IO_SKO:
                            begin
                                if (fgo_reg)
                                begin
                                    state_reg <= S_SKIP;
                                end
                            end
                            bace_pkg::IO_ION: ien_reg <= 1'b1;
                            bace_pkg::IO_IOF: ien_reg <= 1'b0;
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                // interrupt cycle; return address goes to word zero
                S_INTR:
                begin
                    pc_reg    <= AW'(1);
                    ien_reg   <= 1'b0;
                    r_reg     <= 1'b0;
                    state_reg <= S_DONE;
                end

                S_SKIP:
                begin
                    pc_reg    <= alu_sum[AW-1:0];
                    state_reg <= S_DONE;
                end

                // hand the state to the result register once it is free
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        pc_out_reg    <= pc_reg;
                        acc_out_reg   <= acc_reg;
                        e_out_reg     <= e_reg;
                        ien_out_reg   <= ien_reg;
                        fgi_out_reg   <= fgi_reg;
                        fgo_out_reg   <= fgo_reg;
                        r_out_reg     <= r_reg;
                        outr_out_reg  <= outr_reg;
                        halt_out_reg  <= halt_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pc          = pc_out_reg;
    assign acc         = acc_out_reg;
    assign carry_e     = e_out_reg;
    assign int_enable  = ien_out_reg;
    assign in_flag     = fgi_out_reg;
    assign out_flag    = fgo_out_reg;
    assign int_pending = r_out_reg;
    assign out_char    = outr_out_reg;
    assign halted      = halt_out_reg;

endmodule

// File: tb/sv/basic_accumulator_cpu_execute_tb.sv
module basic_accumulator_cpu_execute_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W    = bace_pkg::ADDR_W;
    localparam int WORD_W    = bace_pkg::WORD_W;
    localparam int CHAR_W    = bace_pkg::CHAR_W;
    localparam int MEM_WORDS = bace_pkg::MEM_WORDS;

    // item kinds with no meaning; the block only reports its state
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT = 12000;  // covers the clearing pass over all 4096 memory words

    // visible machine state, in port order
    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] acc;
        logic              carry_e;
        logic              int_enable;
        logic              in_flag;
        logic              out_flag;
        logic              int_pending;
        logic [CHAR_W-1:0] out_char;
        logic              halted;
    } cpu_view_t;

    // Machine copy: tracks every accepted request, queues the state it leads to
    class cpu_state_book;
        logic [WORD_W-1:0] words [MEM_WORDS];
        logic [ADDR_W-1:0] pc_q;
        logic [ADDR_W-1:0] start_pc;
        logic [WORD_W-1:0] ac_q;
        logic              e_q, ien_q, fgi_q, fgo_q, r_q, halt_q;
        logic [CHAR_W-1:0] inr_q, outr_q;
        cpu_view_t         states_due [$];
        int                errors;
        int                checked;
        int                n_instr;
        int                n_irq;
        int                n_halt;

        function new();
            foreach (words[k]) words[k] = '0;
            start_pc = bace_pkg::START_RESET;
            pc_q     = bace_pkg::START_RESET;
            ac_q     = '0;
            {e_q, ien_q, fgi_q, fgo_q, r_q, halt_q} = '0;
            inr_q    = '0;
            outr_q   = '0;
            errors   = 0;
            checked  = 0;
            n_instr  = 0;
            n_irq    = 0;
            n_halt   = 0;
        endfunction

        function int pending();
            return states_due.size();
        endfunction

        function void execute_word(logic [WORD_W-1:0] w);
            logic [ADDR_W-1:0] ea;
            logic [WORD_W:0]   sum;
            logic [WORD_W-1:0] v;
            logic              ne;
            if (w[14:12] != bace_pkg::OP_REG)
            begin
                ea = w[ADDR_W-1:0];
                if (w[15])
                    ea = words[ea][ADDR_W-1:0];
                case (w[14:12])
                    bace_pkg::OP_AND: ac_q = ac_q & words[ea];
                    bace_pkg::OP_ADD:
                    begin
                        sum  = {1'b0, ac_q} + {1'b0, words[ea]};
                        e_q  = sum[WORD_W];
                        ac_q = sum[WORD_W-1:0];
                    end
                    bace_pkg::OP_LDA: ac_q = words[ea];
                    bace_pkg::OP_STA: words[ea] = ac_q;
                    bace_pkg::OP_BUN: pc_q = ea;
                    bace_pkg::OP_BSA:
                    begin
                        words[ea] = {4'h0, pc_q};
                        pc_q = ea + 12'd1;
                    end
                    default:
                    begin
                        // ISZ
                        v = words[ea] + 16'd1;
                        words[ea] = v;
                        if (v == '0)
                            pc_q = pc_q + 12'd1;
                    end
                endcase
            end
            else if (!w[15])
            begin
                case (w)
                    bace_pkg::RR_CLA: ac_q = '0;
                    bace_pkg::RR_CLE: e_q = 1'b0;
                    bace_pkg::RR_CMA: ac_q = ~ac_q;
                    bace_pkg::RR_CME: e_q = ~e_q;
                    bace_pkg::RR_CIR:
                    begin
                        ne   = ac_q[0];
                        ac_q = {e_q, ac_q[15:1]};
                        e_q  = ne;
                    end
                    bace_pkg::RR_CIL:
                    begin
                        ne   = ac_q[15];
                        ac_q = {ac_q[14:0], e_q};
                        e_q  = ne;
                    end
                    bace_pkg::RR_INC: ac_q = ac_q + 16'd1;
                    bace_pkg::RR_SPA: if (!ac_q[15]) pc_q = pc_q + 12'd1;
                    bace_pkg::RR_SNA: if (ac_q[15]) pc_q = pc_q + 12'd1;
                    bace_pkg::RR_SZA: if (ac_q == '0) pc_q = pc_q + 12'd1;
                    bace_pkg::RR_SZE: if (!e_q) pc_q = pc_q + 12'd1;
                    bace_pkg::RR_HLT:
                    begin
                        halt_q = 1'b1;
                        n_halt++;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (w)
                    bace_pkg::IO_INP:
                    begin
                        ac_q[CHAR_W-1:0] = inr_q;
                        fgi_q = 1'b0;
                    end
                    bace_pkg::IO_OUT:
                    begin
                        outr_q = ac_q[CHAR_W-1:0];
                        fgo_q = 1'b0;
                    end
                    bace_pkg::IO_SKI: if (fgi_q) pc_q = pc_q + 12'd1;
                    bace_pkg::IO_SKO: if (fgo_q) pc_q = pc_q + 12'd1;
                    bace_pkg::IO_ION: ien_q = 1'b1;
                    bace_pkg::IO_IOF: ien_q = 1'b0;
                    default: ;
                endcase
            end
        endfunction

        function void advance_tick();
            logic [WORD_W-1:0] w;
            if (halt_q)
                return;
            // interrupt cycle: save PC at 0, vector to 1
            if (r_q)
            begin
                words[0] = {4'h0, pc_q};
                pc_q  = 12'd1;
                ien_q = 1'b0;
                r_q   = 1'b0;
                n_irq++;
                return;
            end
            if (ien_q && (fgi_q || fgo_q))
                r_q = 1'b1;
            w = words[pc_q];
            pc_q = pc_q + 12'd1;
            n_instr++;
            execute_word(w);
        endfunction

        function void note_request(logic [2:0] f, logic [ADDR_W-1:0] a,
                                   logic [WORD_W-1:0] d);
            cpu_view_t s;
            case (f)
                bace_pkg::FUNC_TICK: advance_tick();
                bace_pkg::FUNC_LOAD: words[a] = d;
                bace_pkg::FUNC_INPUT:
                begin
                    fgi_q = ~fgi_q;
                    inr_q = d[CHAR_W-1:0];
                end
                bace_pkg::FUNC_OUT_TGL: fgo_q = ~fgo_q;
                bace_pkg::FUNC_RESTART:
                begin
                    ac_q   = '0;
                    e_q    = 1'b0;
                    outr_q = '0;
                    inr_q  = '0;
                    ien_q  = 1'b0;
                    r_q    = 1'b0;
                    halt_q = 1'b0;
                    pc_q   = start_pc;
                end
                default: ;
            endcase
            s = {pc_q, ac_q, e_q, ien_q, fgi_q, fgo_q, r_q, outr_q, halt_q};
            states_due.push_back(s);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("result %0d: %s", checked, what);
        endtask

        task check_result(cpu_view_t got);
            cpu_view_t want;
            if (states_due.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = states_due.pop_front();
            checked++;
            if (got.pc !== want.pc)
                report_mismatch($sformatf("pc %h, expected %h", got.pc, want.pc));
            if (got.acc !== want.acc)
                report_mismatch($sformatf("acc %h, expected %h", got.acc, want.acc));
            if (got.carry_e !== want.carry_e)
                report_mismatch($sformatf("carry_e %b, expected %b", got.carry_e, want.carry_e));
            if (got.int_enable !== want.int_enable)
                report_mismatch($sformatf("int_enable %b, expected %b",
                                          got.int_enable, want.int_enable));
            if (got.in_flag !== want.in_flag)
                report_mismatch($sformatf("in_flag %b, expected %b", got.in_flag, want.in_flag));
            if (got.out_flag !== want.out_flag)
                report_mismatch($sformatf("out_flag %b, expected %b",
                                          got.out_flag, want.out_flag));
            if (got.int_pending !== want.int_pending)
                report_mismatch($sformatf("int_pending %b, expected %b",
                                          got.int_pending, want.int_pending));
            if (got.out_char !== want.out_char)
                report_mismatch($sformatf("out_char %h, expected %h",
                                          got.out_char, want.out_char));
            if (got.halted !== want.halted)
                report_mismatch($sformatf("halted %b, expected %b", got.halted, want.halted));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        func = '0;
    logic [ADDR_W-1:0] addr = '0;
    logic [WORD_W-1:0] data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    logic              carry_e;
    logic              int_enable;
    logic              in_flag;
    logic              out_flag;
    logic              int_pending;
    logic [CHAR_W-1:0] out_char;
    logic              halted;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;

    cpu_state_book     sb;
    int                send_idle_pct = 17;
    int                recv_idle_pct = 47;
    int                requests_sent = 0;
    int                stall_cycles = 0;
    logic [ADDR_W-1:0] seg_base;
    int                seg_len;
    logic [ADDR_W-1:0] operand_slot [8];

    basic_accumulator_cpu_execute uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .addr        (addr),
        .data        (data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pc          (pc),
        .acc         (acc),
        .carry_e     (carry_e),
        .int_enable  (int_enable),
        .in_flag     (in_flag),
        .out_flag    (out_flag),
        .int_pending (int_pending),
        .out_char    (out_char),
        .halted      (halted),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({pc, acc, carry_e, int_enable, in_flag, out_flag,
                             int_pending, out_char, halted});
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[basic_accumulator_cpu_execute] ERROR");
                $finish;
            end
        end
    end

    // one request; entered and left at a falling edge
    task automatic send_request(input logic [2:0] f, input logic [ADDR_W-1:0] a,
                                input logic [WORD_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        addr     <= a;
        data     <= d;
        do @(posedge clk); while (!in_ready);
        sb.note_request(f, a, d);
        requests_sent++;
        @(negedge clk);
    endtask

    // hold off requests until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_start_address(input logic [ADDR_W-1:0] v);
        drain_results();
        repeat (6) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.start_pc = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // data word: pointer into the operands or the program, an edge value, or noise
    function automatic logic [WORD_W-1:0] random_operand();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        case ($urandom_range(4))
            0: w[ADDR_W-1:0] = operand_slot[3'($urandom_range(7))];
            1: w[ADDR_W-1:0] = ADDR_W'(seg_base + $urandom_range(seg_len - 1));
            2:
            begin
                case ($urandom_range(3))
                    0: w = 16'hFFFF;
                    1: w = 16'h0000;
                    2: w = 16'h8000;
                    default: w = 16'h7FFF;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_instruction();
        logic [2:0]        op;
        logic [ADDR_W-1:0] target;
        logic [WORD_W-1:0] w;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                // memory reference; branches mostly stay inside the program
                op = 3'($urandom_range(6));
                target = operand_slot[3'($urandom_range(7))];
                if ((op == bace_pkg::OP_BUN || op == bace_pkg::OP_BSA) &&
                    $urandom_range(9) < 7)
                    target = ADDR_W'(seg_base + $urandom_range(seg_len - 1));
                w = {1'b0, op, target};
                w[15] = 1'($urandom_range(1));
            end
            4, 5, 6:
            begin
                case ($urandom_range(11))
                    0: w = bace_pkg::RR_CLA;
                    1: w = bace_pkg::RR_CLE;
                    2: w = bace_pkg::RR_CMA;
                    3: w = bace_pkg::RR_CME;
                    4: w = bace_pkg::RR_CIR;
                    5: w = bace_pkg::RR_CIL;
                    6: w = bace_pkg::RR_INC;
                    7: w = bace_pkg::RR_SPA;
                    8: w = bace_pkg::RR_SNA;
                    9: w = bace_pkg::RR_SZA;
                    10: w = bace_pkg::RR_SZE;
                    default: w = bace_pkg::RR_HLT;
                endcase
            end
            7, 8:
            begin
                case ($urandom_range(5))
                    0: w = bace_pkg::IO_INP;
                    1: w = bace_pkg::IO_OUT;
                    2: w = bace_pkg::IO_SKI;
                    3: w = bace_pkg::IO_SKO;
                    4: w = bace_pkg::IO_ION;
                    default: w = bace_pkg::IO_IOF;
                endcase
            end
            default:
            begin
                // inexact register/I-O codes, or any word at all
                w = WORD_W'($urandom);
                case ($urandom_range(2))
                    0: w[15:12] = 4'h7;
                    1: w[15:12] = 4'hF;
                    default: ;
                endcase
            end
        endcase
        return w;
    endfunction

    // load operands and a short program, restart, then mostly ticks
    task automatic run_program();
        int                n_steps;
        logic [ADDR_W-1:0] vec_off;
        seg_base = sb.start_pc;
        seg_len  = int'($urandom_range(16, 4));
        n_steps  = int'($urandom_range(40, 8));
        foreach (operand_slot[k])
            operand_slot[k] = ADDR_W'($urandom_range(4095));
        foreach (operand_slot[k])
            send_request(bace_pkg::FUNC_LOAD, operand_slot[k], random_operand());
        for (int i = 0; i < seg_len; i++)
            send_request(bace_pkg::FUNC_LOAD, ADDR_W'(seg_base + i), random_instruction());
        // interrupt vector jumps back to the program start, when word 1 lies outside it
        vec_off = 12'd1 - seg_base;
        if (int'(vec_off) >= seg_len)
            send_request(bace_pkg::FUNC_LOAD, 12'd1, {1'b0, bace_pkg::OP_BUN, seg_base});
        // now and then carry on from wherever the last program stopped
        if ($urandom_range(9) != 0)
            send_request(bace_pkg::FUNC_RESTART, ADDR_W'($urandom), WORD_W'($urandom));
        for (int i = 0; i < n_steps; i++)
        begin
            case ($urandom_range(19))
                0: send_request(bace_pkg::FUNC_INPUT, ADDR_W'($urandom), WORD_W'($urandom));
                1: send_request(bace_pkg::FUNC_OUT_TGL, ADDR_W'($urandom), WORD_W'($urandom));
                2: send_request(bace_pkg::FUNC_LOAD, ADDR_W'($urandom), WORD_W'($urandom));
                3: send_request(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)),
                                ADDR_W'($urandom), WORD_W'($urandom));
                default: send_request(bace_pkg::FUNC_TICK, ADDR_W'($urandom), WORD_W'($urandom));
            endcase
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    // fixed program at the reset start address: wrap, carry, indirect ISZ skip, halt
    task automatic run_directed();
        send_request(bace_pkg::FUNC_LOAD, 12'h000, 16'h0000);
        send_request(bace_pkg::FUNC_LOAD, 12'hFFF, 16'hFFFF);
        send_request(bace_pkg::FUNC_LOAD, 12'hFFE, 16'hF0FF);  // pointer, upper bits dropped
        send_request(bace_pkg::FUNC_LOAD, 12'h0FF, 16'hFFFF);
        send_request(bace_pkg::FUNC_LOAD, 12'h100, {1'b0, bace_pkg::OP_LDA, 12'hFFF});
        send_request(bace_pkg::FUNC_LOAD, 12'h101, {1'b0, bace_pkg::OP_ADD, 12'hFFF});
        send_request(bace_pkg::FUNC_LOAD, 12'h102, {1'b1, bace_pkg::OP_ISZ, 12'hFFE});
        send_request(bace_pkg::FUNC_LOAD, 12'h104, bace_pkg::RR_CIL);
        send_request(bace_pkg::FUNC_LOAD, 12'h105, bace_pkg::RR_HLT);
        repeat (5) send_request(bace_pkg::FUNC_TICK, 12'h000, 16'h0000);
        // tick while halted
        send_request(bace_pkg::FUNC_TICK, 12'hFFF, 16'hFFFF);
        send_request(bace_pkg::FUNC_INPUT, 12'h000, 16'hFFFF);
        send_request(bace_pkg::FUNC_OUT_TGL, 12'hFFF, 16'h0000);
        send_request(FUNC_SPARE_HI, 12'hFFF, 16'hFFFF);
        send_request(FUNC_SPARE_LO, 12'h000, 16'h0000);
        send_request(bace_pkg::FUNC_RESTART, 12'hFFF, 16'hFFFF);
        send_request(bace_pkg::FUNC_TICK, 12'h000, 16'h0000);
    endtask

    initial
    begin
        int                target;
        logic [ADDR_W-1:0] mid_start;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // sender light, receiver heavy; lowest start address
        write_start_address(12'h000);
        target = requests_sent + 640;
        while (requests_sent < target)
            run_program();

        // sender heavy, receiver light; highest start address, program wraps
        send_idle_pct = 47;
        recv_idle_pct = 17;
        write_start_address(12'hFFF);
        target = requests_sent + 640;
        while (requests_sent < target)
            run_program();

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mid_start = ADDR_W'($urandom_range(4094, 2));
        write_start_address(mid_start);
        target = requests_sent + 640;
        while (requests_sent < target)
            run_program();

        drain_results();
        repeat (16) @(negedge clk);

        $display("%0d requests, %0d results checked, start addresses 100/000/fff/%h",
                 requests_sent, sb.checked, mid_start);
        $display("%0d instructions executed, %0d interrupt cycles, %0d halts",
                 sb.n_instr, sb.n_irq, sb.n_halt);
        if (sb.errors == 0)
            $display("[basic_accumulator_cpu_execute] OK");
        else
            $display("[basic_accumulator_cpu_execute] ERROR");
        $finish;
    end

endmodule
